[src/rmf_pkg.sv]
// Package for the RGB 3x3 median filter: pixel and result types and fixed widths.
// No dependencies; every other file of the block but rmf_fifo uses it by scoped names.
package rmf_pkg;

   // Width of one color channel and of one packed pixel (red low, blue high).
   localparam int CHAN_W = 8;
   localparam int NUM_CHAN = 3;
   localparam int PIX_W = CHAN_W * NUM_CHAN;

   // One incoming pixel with its load mode flag.
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              full_load;
   } req_type;

   // One result: the median of every channel over the window.
   typedef struct packed {
      logic [CHAN_W-1:0] median_red;
      logic [CHAN_W-1:0] median_green;
      logic [CHAN_W-1:0] median_blue;
   } rsp_type;

endpackage

[src/rmf_fifo.sv]
// Small register FIFO with push/full and pop/empty sides.
// Used for the window queue and the result queue; depends on nothing else.
module rmf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/rmf_front.sv]
// Front end of the median filter: places accepted pixels into the window and
// hands each completed window on. Depends on rmf_pkg.
module rmf_front #(
   parameter int WINDOW_SIZE = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  rmf_pkg::req_type        in_pix,
   output logic                    win_valid,
   output logic [WINDOW_SIZE*WINDOW_SIZE*rmf_pkg::PIX_W-1:0] win_data
);

   localparam int N     = WINDOW_SIZE;
   localparam int POS_W = $clog2(N);
   localparam int ROW_W = $clog2(N + 1);

   // Window is indexed [column][row].
   logic [N-1:0][N-1:0][rmf_pkg::PIX_W-1:0]   win_ff, win_in;
   logic [N-2:0][N-1:0][rmf_pkg::PIX_W-1:0]   saved_ff, saved_in;
   logic [POS_W-1:0]                          row_ff, row_in;
   logic [POS_W-1:0]                          col_ff, col_in;
   logic [ROW_W-1:0]                          row_next;
   logic [rmf_pkg::PIX_W-1:0]                 pix;
   logic                                      done;

   assign pix = {in_pix.blue, in_pix.green, in_pix.red};

   always_comb begin
      win_in   = win_ff;
      saved_in = saved_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      row_next = ROW_W'(row_ff);
      done     = 1'b0;
      if (in_valid) begin
         if (in_pix.full_load) begin
            win_in[col_ff][row_ff] = pix;
            if (col_ff == POS_W'(N - 1)) begin
               col_in   = '0;
               row_next = ROW_W'(row_ff) + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end else begin
            // Leading columns come back from the saved copy, the new column
            // takes the pixel at the current row.
            for (int c = 0; c < N - 1; c++) begin
               win_in[c] = saved_ff[c];
            end
            win_in[N-1][row_ff] = pix;
            col_in   = '0;
            row_next = ROW_W'(row_ff) + 1'b1;
         end
         if (row_next == ROW_W'(N)) begin
            done   = 1'b1;
            row_in = '0;
            for (int c = 0; c < N - 1; c++) begin
               saved_in[c] = win_in[c+1];
            end
         end else begin
            row_in = row_next[POS_W-1:0];
         end
      end
   end

   assign win_valid = done;
   assign win_data  = win_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         saved_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         win_ff   <= win_in;
         saved_ff <= saved_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

endmodule

[src/rmf_median.sv]
// Back end of the median filter: a two-stage rank network that picks the
// median of every channel of one window. Depends on rmf_pkg.
module rmf_median #(
   parameter int WINDOW_SIZE = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [WINDOW_SIZE*WINDOW_SIZE*rmf_pkg::PIX_W-1:0] in_window,
   output logic                    in_ready,
   output logic                    out_valid,
   output rmf_pkg::rsp_type        out_data,
   input  logic                    out_ready
);

   localparam int CELLS  = WINDOW_SIZE * WINDOW_SIZE;
   localparam int RANK_W = $clog2(CELLS);
   localparam int MID    = CELLS / 2;
   localparam int NCH    = rmf_pkg::NUM_CHAN;
   localparam int CW     = rmf_pkg::CHAN_W;

   typedef logic [CELLS-1:0][NCH-1:0][CW-1:0] vals_type;

   vals_type                                 in_vals;
   vals_type                                 s1_val_ff, s2_val_ff;
   logic [NCH-1:0][CELLS-1:0][CELLS-1:0]     lt_in, lt_ff;
   logic [NCH-1:0][CELLS-1:0][RANK_W-1:0]    rank_in, rank_ff;
   logic                                     s1_valid_ff, s2_valid_ff;
   logic                                     advance;
   logic [NCH-1:0][CW-1:0]                   med;

   assign in_vals   = in_window;
   assign advance   = !s2_valid_ff || out_ready;
   assign in_ready  = advance;
   assign out_valid = s2_valid_ff;

   // Stage 1 inputs: element j counts below element i when it is smaller, or
   // equal and earlier, so the ranks form a permutation even with ties.
   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         for (int i = 0; i < CELLS; i++) begin
            for (int j = 0; j < CELLS; j++) begin
               lt_in[ch][i][j] = (in_vals[j][ch] < in_vals[i][ch]) ||
                                 ((in_vals[j][ch] == in_vals[i][ch]) && (j < i));
            end
         end
      end
   end

   // Stage 2 inputs: the rank of every element is the count of its flags.
   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         for (int i = 0; i < CELLS; i++) begin
            rank_in[ch][i] = '0;
            for (int j = 0; j < CELLS; j++) begin
               rank_in[ch][i] = rank_in[ch][i] + RANK_W'(lt_ff[ch][i][j]);
            end
         end
      end
   end

   // Exactly one element per channel holds the middle rank.
   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         med[ch] = '0;
         for (int i = 0; i < CELLS; i++) begin
            if (rank_ff[ch][i] == RANK_W'(MID)) begin
               med[ch] = med[ch] | s2_val_ff[i][ch];
            end
         end
      end
   end

   assign out_data.median_red   = med[0];
   assign out_data.median_green = med[1];
   assign out_data.median_blue  = med[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_val_ff <= in_vals;
         lt_ff     <= lt_in;
         s2_val_ff <= s1_val_ff;
         rank_ff   <= rank_in;
      end
   end

endmodule

[src/rgb_median_filter_3x3.sv]
// Top level of the RGB 3x3 median filter: front end, window queue, median
// back end and result queue. Depends on rmf_pkg, rmf_fifo, rmf_front, rmf_median.
//
//   Channel   Ports                     Direction  Transfer when
//   request   push, full, req_data      in         push && !full
//   response  pop, empty, rsp_data      out        pop && !empty
//
// One pixel transfer is taken in every cycle while the window queue has room.
// A pixel that completes a window reaches rsp_data through the window queue,
// which is written at the transfer edge, then the rank network (compare,
// then count and select) and then the result queue.
// Reset is synchronous and active high; it clears the window, the saved
// columns, the row and column positions and both queues.
// When the result queue fills, the rank network holds, the window queue
// fills behind it, and full rises; a stalled response side never loses data.
module rgb_median_filter_3x3 #(
   parameter int WINDOW_SIZE = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  rmf_pkg::req_type req_data,
   input  logic             pop,
   output logic             empty,
   output rmf_pkg::rsp_type rsp_data
);

   localparam int WIN_W = WINDOW_SIZE * WINDOW_SIZE * rmf_pkg::PIX_W;
   localparam int RSP_W = $bits(rmf_pkg::rsp_type);

   logic             accept;
   logic             win_valid;
   logic [WIN_W-1:0] win_data;
   logic [WIN_W-1:0] wq_data;
   logic             wq_empty;
   logic             wq_pop;
   logic             med_ready;
   logic             med_valid;
   rmf_pkg::rsp_type med_data;
   logic             rq_full;
   logic [RSP_W-1:0] rq_data;

   // A pixel is taken whenever the window queue can absorb a finished window.
   assign accept = push && !full;

   rmf_front #(
      .WINDOW_SIZE(WINDOW_SIZE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_pix   (req_data),
      .win_valid(win_valid),
      .win_data (win_data)
   );

   // Completed windows wait here so the front end keeps running while the
   // back end is held by the response side.
   rmf_fifo #(
      .WIDTH(WIN_W),
      .DEPTH(2)
   ) u_win_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (win_valid),
      .push_data(win_data),
      .full     (full),
      .pop      (wq_pop),
      .pop_data (wq_data),
      .empty    (wq_empty)
   );

   assign wq_pop = med_ready && !wq_empty;

   rmf_median #(
      .WINDOW_SIZE(WINDOW_SIZE)
   ) u_median (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!wq_empty),
      .in_window(wq_data),
      .in_ready (med_ready),
      .out_valid(med_valid),
      .out_data (med_data),
      .out_ready(!rq_full)
   );

   // The result queue is the output register stage toward the consumer.
   rmf_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(2)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (med_valid),
      .push_data(med_data),
      .full     (rq_full),
      .pop      (pop),
      .pop_data (rq_data),
      .empty    (empty)
   );

   assign rsp_data = rq_data;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rgb_median_filter_3x3: drives pixels, predicts each window median.
// Depends on rmf_pkg and on the RTL of the filter; no other files are needed.

module tb_top;

   // Geometry of the window and the bounds of the run.
   localparam int WIN = 3;
   localparam int CELLS = WIN * WIN;
   localparam int RANDOM_ITEMS = 1400;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT = 300000;
   localparam int MAX_PRINTED = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full;
   logic empty;
   rmf_pkg::req_type req_data = '0;
   rmf_pkg::rsp_type rsp_data;

   rgb_median_filter_3x3 #(
      .WINDOW_SIZE(WIN)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .pop     (pop),
      .empty   (empty),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state. Pixels are kept packed as {blue, green, red}, indexed
   // [column][row], the same way the filter lays out its window.
   logic [rmf_pkg::PIX_W-1:0] win_pix [WIN][WIN] = '{default: '0};
   logic [rmf_pkg::PIX_W-1:0] saved_col [WIN-1][WIN] = '{default: '0};
   int unsigned row_pos = 0;
   int unsigned col_pos = 0;

   // Medians still owed by the filter, oldest first.
   rmf_pkg::rsp_type expected_medians [$];

   int cycle_count = 0;
   int error_count = 0;
   int pixels_sent = 0;
   int medians_checked = 0;
   int burst_left = 0;
   int value_style = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // The run must never take longer than this; a hang is a failure.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d medians outstanding.",
               CYCLE_LIMIT, expected_medians.size());
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("Mismatch at cycle %0d: %s got %0d expected %0d",
                  cycle_count, what, got, want);
      end
   endtask

   // Median of one channel: the middle element of the nine sorted values.
   function automatic logic [7:0] channel_median(input int lsb);
      logic [7:0] vals [CELLS];
      logic [7:0] key;
      int n;
      int j;
      n = 0;
      for (int c = 0; c < WIN; c++) begin
         for (int r = 0; r < WIN; r++) begin
            vals[n] = win_pix[c][r][lsb +: 8];
            n++;
         end
      end
      for (int i = 1; i < CELLS; i++) begin
         key = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > key) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = key;
      end
      return vals[CELLS/2];
   endfunction

   // Places one accepted pixel in the window. Returns 1 and the medians when
   // the pixel completes the window.
   function automatic bit advance_window(input rmf_pkg::req_type px,
                                         output rmf_pkg::rsp_type med);
      logic [rmf_pkg::PIX_W-1:0] pix;
      pix = {px.blue, px.green, px.red};
      med = '0;
      if (row_pos >= WIN) row_pos = 0;
      if (col_pos >= WIN) col_pos = 0;
      if (px.full_load) begin
         // Row-major fill of the whole window.
         win_pix[col_pos][row_pos] = pix;
         col_pos++;
         if (col_pos >= WIN) begin
            col_pos = 0;
            row_pos++;
         end
      end else begin
         // Sliding mode: the leading columns come back from the saved copy,
         // which wipes out anything a flagged pixel put there.
         for (int c = 0; c < WIN - 1; c++) begin
            for (int r = 0; r < WIN; r++) begin
               win_pix[c][r] = saved_col[c][r];
            end
         end
         win_pix[WIN-1][row_pos] = pix;
         col_pos = 0;
         row_pos++;
      end
      if (row_pos < WIN) return 1'b0;
      row_pos = 0;
      for (int c = 0; c < WIN - 1; c++) begin
         for (int r = 0; r < WIN; r++) begin
            saved_col[c][r] = win_pix[c+1][r];
         end
      end
      med.median_red = channel_median(0);
      med.median_green = channel_median(8);
      med.median_blue = channel_median(16);
      return 1'b1;
   endfunction

   function automatic rmf_pkg::req_type make_pixel(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b, input logic load);
      rmf_pkg::req_type px;
      px.red = r;
      px.green = g;
      px.blue = b;
      px.full_load = load;
      return px;
   endfunction

   // Channel values follow the style chosen for the current sequence: full
   // range, a tiny range that forces ties, or only the two extremes.
   function automatic logic [7:0] random_channel();
      logic [7:0] v;
      if (value_style == 1) v = 8'($urandom_range(0, 3));
      else if (value_style == 2) v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else v = 8'($urandom);
      return v;
   endfunction

   function automatic rmf_pkg::req_type random_pixel(input logic load);
      return make_pixel(random_channel(), random_channel(), random_channel(), load);
   endfunction

   // Sends one pixel and waits for its transfer. The sender works in bursts;
   // when a burst runs out it may drop push for a random gap first. Push is
   // only lowered here and after the last pixel, never in the step it is
   // raised again.
   task automatic send_pixel(input rmf_pkg::req_type px);
      rmf_pkg::rsp_type med;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (full) @(posedge clock);
      if (advance_window(px, med)) expected_medians.push_back(med);
      pixels_sent++;
   endtask

   // Result side: compare every transfer with the oldest expected median,
   // then decide pop for the next edge from a rotating stall pattern. The
   // pattern is redrawn whenever pattern_age comes round; one draw in four never stalls.
   logic [15:0] stall_pattern = 16'hFFFF;
   int pattern_age = 0;

   always @(posedge clock) begin : result_check
      rmf_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_medians.size() == 0) begin
            report_mismatch("result with no window pending, red", rsp_data.median_red, 0);
         end else begin
            want = expected_medians.pop_front();
            medians_checked++;
            if (rsp_data.median_red !== want.median_red)
               report_mismatch("median_red", rsp_data.median_red, want.median_red);
            if (rsp_data.median_green !== want.median_green)
               report_mismatch("median_green", rsp_data.median_green, want.median_green);
            if (rsp_data.median_blue !== want.median_blue)
               report_mismatch("median_blue", rsp_data.median_blue, want.median_blue);
         end
      end
      pattern_age++;
      if (pattern_age == 64) begin
         pattern_age = 0;
         case ($urandom_range(0, 3))
            0: stall_pattern = 16'hFFFF;
            1: stall_pattern = 16'($urandom) | 16'h0001;
            2: stall_pattern = 16'h0001 << $urandom_range(0, 15);
            default: stall_pattern = 16'($urandom | $urandom) | 16'h0001;
         endcase
      end else begin
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
      pop <= stall_pattern[0];
   end

   // A full window of flagged pixels. Red is distinct and descending so the
   // median index is exercised; green and blue mix the extremes 0 and 255.
   task automatic test_full_load_window();
      logic [7:0] r;
      for (int i = 0; i < CELLS; i++) begin
         r = (i == CELLS - 1) ? 8'h00 : 8'(255 - i * 31);
         send_pixel(make_pixel(r, (i < 4) ? 8'h00 : 8'hFF, (i % 2) ? 8'hFF : 8'h00, 1'b1));
      end
   endtask

   // Three unflagged pixels slide a new column in next to the saved ones.
   task automatic test_column_slide();
      send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b0));
      send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 1'b0));
      send_pixel(make_pixel(8'h80, 8'h7F, 8'h01, 1'b0));
   endtask

   // Flagged pixels written into the leading columns are then overwritten by
   // an unflagged pixel in the same window, and the column position resets.
   task automatic test_mixed_modes();
      send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_pixel(make_pixel(8'hFE, 8'h01, 8'hFF, 1'b1));
      send_pixel(make_pixel(8'h10, 8'h20, 8'h30, 1'b0));
      send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_pixel(make_pixel(8'h00, 8'hAA, 8'h55, 1'b0));
      send_pixel(make_pixel(8'hFF, 8'h55, 8'hAA, 1'b0));
   endtask

   // Mostly well-formed sequences (whole flagged windows or whole sliding
   // columns) with random content, plus some mixed and lone pixels.
   task automatic test_random_stream();
      int sent;
      int kind;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         value_style = $urandom_range(0, 3);
         if (kind <= 4) begin
            repeat (CELLS) send_pixel(random_pixel(1'b1));
            sent += CELLS;
         end else if (kind <= 7) begin
            repeat (WIN) send_pixel(random_pixel(1'b0));
            sent += WIN;
         end else if (kind == 8) begin
            repeat ($urandom_range(1, 6)) begin
               send_pixel(random_pixel(1'($urandom_range(0, 1))));
               sent++;
            end
         end else begin
            value_style = 2;
            send_pixel(random_pixel(1'($urandom_range(0, 1))));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_full_load_window();
      test_column_slide();
      test_mixed_modes();
      test_random_stream();

      // Drop push after the last transfer, let every owed median arrive, and
      // then keep watching for anything unexpected.
      push <= 1'b0;
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d pixels in flagged, sliding and mixed load modes.", pixels_sent);
      $display("Checked %0d window medians per channel; %0d mismatches.",
               medians_checked, error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
